// ===== sv/tqm_pkg.sv =====
// shared types and constants for the triangle quality datapath
`timescale 1ns / 1ps
`default_nettype none
package tqm_pkg;

  localparam int COORD_BITS = 16;
  localparam int LEN_XBITS  = 8;
  localparam int QW         = 32;
  localparam int KW         = 32;

  // coordinate difference, signed
  localparam int DW   = COORD_BITS + 1;
  // one squared difference, unsigned
  localparam int SQW  = 2 * COORD_BITS + 1;
  // squared side length
  localparam int D2W  = SQW + 1;
  // radicand: squared length with extra fraction bits, and its root
  localparam int NW   = D2W + 2 * LEN_XBITS;
  localparam int RW   = NW / 2;
  localparam int RMW  = RW + 2;
  localparam int LSW  = RW + 2;
  // twice the area, sum of squared sides, and its double
  localparam int A2W  = 2 * COORD_BITS + 2;
  localparam int HW   = D2W + 2;
  localparam int H2W  = HW + 1;
  // longest side times perimeter, split for the constant multiply
  localparam int P1W  = RW + LSW;
  localparam int P1H  = P1W / 2;
  localparam int H2H  = H2W / 2;
  localparam int N1W  = P1W + KW;
  localparam int N2W  = H2W + KW;
  // dividend width of the saturating divider
  localparam int DVW  = (P1W > H2W + 16) ? P1W : H2W + 16;

  localparam logic [KW-1:0] K_ONE = 32'd1239850262;
  localparam logic [KW-1:0] K_TWO = 32'd1290477068;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } vertices_t;

  typedef struct packed {
    logic [QW-1:0] quality_one;
    logic [QW-1:0] quality_two;
    logic          degenerate;
  } result_t;

  // values that ride along the square root pipeline
  typedef struct packed {
    logic [A2W-1:0] a2;
    logic [HW-1:0]  hsum;
  } sqrt_side_t;

endpackage
`default_nettype wire

// ===== sv/tqm_isqrt.sv =====
// three-lane pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tqm_isqrt (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [2:0][tqm_pkg::NW-1:0]         radicand,
  input  wire tqm_pkg::sqrt_side_t                 in_side,
  output logic                                     out_valid,
  output logic [2:0][tqm_pkg::RW-1:0]              root,
  output tqm_pkg::sqrt_side_t                      out_side
);

  localparam int NW  = tqm_pkg::NW;
  localparam int RW  = tqm_pkg::RW;
  localparam int RMW = tqm_pkg::RMW;

  logic [RW-1:0]             vld;
  tqm_pkg::sqrt_side_t       side_q [RW];
  logic [2:0][NW-1:0]        n_q    [RW];
  logic [2:0][RMW-1:0]       rem_q  [RW];
  logic [2:0][RW-1:0]        root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic                    vld_prev;
    tqm_pkg::sqrt_side_t     side_prev;
    logic [2:0][NW-1:0]      n_prev;
    logic [2:0][RMW-1:0]     rem_prev;
    logic [2:0][RW-1:0]      root_prev;
    logic [2:0][RMW-1:0]     rem_next;
    logic [2:0][RW-1:0]      root_next;

    if (k == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign side_prev = in_side;
      assign n_prev    = radicand;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign vld_prev  = vld[k-1];
      assign side_prev = side_q[k-1];
      assign n_prev    = n_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
    end

    always_comb begin
      logic [RMW+1:0] t;
      logic [RMW+1:0] trial;
      logic [RMW+1:0] d;
      for (int l = 0; l < 3; l++) begin
        t     = {rem_prev[l], n_prev[l][NW-1:NW-2]};
        trial = {2'b00, root_prev[l], 2'b01};
        d     = t - trial;
        if (t >= trial) begin
          rem_next[l]  = d[RMW-1:0];
          root_next[l] = {root_prev[l][RW-2:0], 1'b1};
        end else begin
          rem_next[l]  = t[RMW-1:0];
          root_next[l] = {root_prev[l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_prev;
      end
      side_q[k] <= side_prev;
      for (int l = 0; l < 3; l++) begin
        n_q[k][l] <= n_prev[l] << 2;
      end
      rem_q[k]  <= rem_next;
      root_q[k] <= root_next;
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule
`default_nettype wire

// ===== sv/tqm_divider.sv =====
// two-lane pipelined saturating divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tqm_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [1:0][tqm_pkg::DVW-1:0]      dividend,
  input  wire logic [tqm_pkg::A2W-1:0]           divisor,
  input  wire logic                              in_degenerate,
  output logic                                   out_valid,
  output logic [1:0][tqm_pkg::QW-1:0]            quotient,
  output logic                                   out_degenerate
);

  localparam int DVW = tqm_pkg::DVW;
  localparam int A2W = tqm_pkg::A2W;
  localparam int QW  = tqm_pkg::QW;
  localparam int NS  = QW + 1;

  logic [NS-1:0]             vld;
  logic [NS-1:0]             dgn_q;
  logic [A2W-1:0]            dvs_q [NS];
  logic [1:0]                ovf_q [NS];
  logic [1:0][A2W-1:0]       rem_q [NS];
  logic [1:0][QW-1:0]        lo_q  [NS];
  logic [1:0][QW-1:0]        q_q   [NS];

  // first stage: overflow check and initial remainder from the high part
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    dgn_q[0] <= in_degenerate;
    dvs_q[0] <= divisor;
    for (int l = 0; l < 2; l++) begin
      ovf_q[0][l] <= A2W'(dividend[l][DVW-1:QW]) >= divisor;
      rem_q[0][l] <= A2W'(dividend[l][DVW-1:QW]);
      lo_q[0][l]  <= dividend[l][QW-1:0];
      q_q[0][l]   <= '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [1:0][A2W-1:0] rem_next;
    logic [1:0]          bit_next;

    always_comb begin
      logic [A2W:0] t;
      logic [A2W:0] d;
      for (int l = 0; l < 2; l++) begin
        t = {rem_q[k-1][l], lo_q[k-1][l][QW-1]};
        d = t - {1'b0, dvs_q[k-1]};
        bit_next[l] = t >= {1'b0, dvs_q[k-1]};
        rem_next[l] = bit_next[l] ? d[A2W-1:0] : t[A2W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      dgn_q[k] <= dgn_q[k-1];
      dvs_q[k] <= dvs_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      rem_q[k] <= rem_next;
      for (int l = 0; l < 2; l++) begin
        lo_q[k][l] <= lo_q[k-1][l] << 1;
        q_q[k][l]  <= {q_q[k-1][l][QW-2:0], bit_next[l]};
      end
    end
  end

  assign out_valid      = vld[NS-1];
  assign out_degenerate = dgn_q[NS-1];
  assign quotient[0]    = ovf_q[NS-1][0] ? '1 : q_q[NS-1][0];
  assign quotient[1]    = ovf_q[NS-1][1] ? '1 : q_q[NS-1][1];

endmodule
`default_nettype wire

// ===== sv/triangle_quality_measures.sv =====
// top level: triangle quality measures Q1 and Q2 from three vertices
// Fully pipelined: a triangle is taken in every cycle (busy stays low) and
// its result appears on result with a one-cycle done strobe; the receiver
// cannot stall, so it must take each result when done is high. The pipeline
// holds the 25-stage side-length square root and the 33-stage saturating
// divider, plus ten stages of difference, square, area, multiply and output
// registers. A zero-area triangle gives all ones in both measures with
// degenerate set.
`timescale 1ns / 1ps
`default_nettype none
module triangle_quality_measures (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tqm_pkg::vertices_t  vertices,
  output logic                     done,
  output tqm_pkg::result_t         result
);

  localparam int DW   = tqm_pkg::DW;
  localparam int SQW  = tqm_pkg::SQW;
  localparam int D2W  = tqm_pkg::D2W;
  localparam int NW   = tqm_pkg::NW;
  localparam int RW   = tqm_pkg::RW;
  localparam int LSW  = tqm_pkg::LSW;
  localparam int A2W  = tqm_pkg::A2W;
  localparam int HW   = tqm_pkg::HW;
  localparam int H2W  = tqm_pkg::H2W;
  localparam int P1W  = tqm_pkg::P1W;
  localparam int P1H  = tqm_pkg::P1H;
  localparam int H2H  = tqm_pkg::H2H;
  localparam int N1W  = tqm_pkg::N1W;
  localparam int N2W  = tqm_pkg::N2W;
  localparam int KW   = tqm_pkg::KW;
  localparam int DVW  = tqm_pkg::DVW;
  localparam int LX   = tqm_pkg::LEN_XBITS;

  assign busy = 1'b0;

  // s0: input register
  logic               v0;
  tqm_pkg::vertices_t vtx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    vtx <= vertices;
  end

  // s1: coordinate differences
  logic                 v1;
  logic signed [DW-1:0] dx12, dy12, dx23, dy23, dx31, dy31;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    dx12 <= DW'(vtx.ax) - DW'(vtx.bx);
    dy12 <= DW'(vtx.ay) - DW'(vtx.by_coord);
    dx23 <= DW'(vtx.bx) - DW'(vtx.cx);
    dy23 <= DW'(vtx.by_coord) - DW'(vtx.cy);
    dx31 <= DW'(vtx.cx) - DW'(vtx.ax);
    dy31 <= DW'(vtx.cy) - DW'(vtx.ay);
  end

  // s2: squares and cross products
  logic signed [2*DW-1:0] mx12, my12, mx23, my23, mx31, my31, crs_p, crs_q;
  logic                   v2;
  logic [SQW-1:0]         sx12, sy12, sx23, sy23, sx31, sy31;
  logic signed [2*DW-1:0] pr_p, pr_q;

  always_comb begin
    mx12  = dx12 * dx12;
    my12  = dy12 * dy12;
    mx23  = dx23 * dx23;
    my23  = dy23 * dy23;
    mx31  = dx31 * dx31;
    my31  = dy31 * dy31;
    // (b-a) x (c-a) written with the side differences
    crs_p = dx31 * dy12;
    crs_q = dx12 * dy31;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sx12 <= mx12[SQW-1:0];
    sy12 <= my12[SQW-1:0];
    sx23 <= mx23[SQW-1:0];
    sy23 <= my23[SQW-1:0];
    sx31 <= mx31[SQW-1:0];
    sy31 <= my31[SQW-1:0];
    pr_p <= crs_p;
    pr_q <= crs_q;
  end

  // s3: squared lengths and signed doubled area
  logic                 v3;
  logic [D2W-1:0]       d12, d23, d31;
  logic signed [2*DW:0] crs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    d12 <= D2W'(sx12) + D2W'(sy12);
    d23 <= D2W'(sx23) + D2W'(sy23);
    d31 <= D2W'(sx31) + D2W'(sy31);
    crs <= (2*DW+1)'(pr_p) - (2*DW+1)'(pr_q);
  end

  // s4: area magnitude, sum of squares, radicands
  logic                  v4;
  logic [2:0][NW-1:0]    rad;
  tqm_pkg::sqrt_side_t   side4;
  logic signed [2*DW:0]  crs_abs;

  assign crs_abs = crs[2*DW] ? -crs : crs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    rad[0]     <= {d12, {(2*LX){1'b0}}};
    rad[1]     <= {d23, {(2*LX){1'b0}}};
    rad[2]     <= {d31, {(2*LX){1'b0}}};
    side4.a2   <= crs_abs[A2W-1:0];
    side4.hsum <= HW'(d12) + HW'(d23) + HW'(d31);
  end

  logic                 vs;
  logic [2:0][RW-1:0]   len;
  tqm_pkg::sqrt_side_t  side_s;

  tqm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .radicand  (rad),
    .in_side   (side4),
    .out_valid (vs),
    .root      (len),
    .out_side  (side_s)
  );

  // s5: longest side and perimeter
  logic           v5;
  logic [RW-1:0]  lmax;
  logic [LSW-1:0] lsum;
  logic [A2W-1:0] a2_5;
  logic [HW-1:0]  hsum5;
  logic [RW-1:0]  lmax_ab;

  assign lmax_ab = (len[0] < len[1]) ? len[1] : len[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= vs;
    end
    lmax  <= (lmax_ab < len[2]) ? len[2] : lmax_ab;
    lsum  <= LSW'(len[0]) + LSW'(len[1]) + LSW'(len[2]);
    a2_5  <= side_s.a2;
    hsum5 <= side_s.hsum;
  end

  // s6: longest side times perimeter
  logic           v6;
  logic [P1W-1:0] p1;
  logic [H2W-1:0] h2;
  logic [A2W-1:0] a2_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    p1   <= P1W'(lmax) * P1W'(lsum);
    h2   <= {hsum5, 1'b0};
    a2_6 <= a2_5;
  end

  // s7: constant multiplies in two halves each
  logic                   v7;
  logic [P1H+KW-1:0]      pl1;
  logic [P1W-P1H+KW-1:0]  ph1;
  logic [H2H+KW-1:0]      pl2;
  logic [H2W-H2H+KW-1:0]  ph2;
  logic [A2W-1:0]         a2_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    pl1  <= (P1H+KW)'(p1[P1H-1:0]) * (P1H+KW)'(tqm_pkg::K_ONE);
    ph1  <= (P1W-P1H+KW)'(p1[P1W-1:P1H]) * (P1W-P1H+KW)'(tqm_pkg::K_ONE);
    pl2  <= (H2H+KW)'(h2[H2H-1:0]) * (H2H+KW)'(tqm_pkg::K_TWO);
    ph2  <= (H2W-H2H+KW)'(h2[H2W-1:H2H]) * (H2W-H2H+KW)'(tqm_pkg::K_TWO);
    a2_7 <= a2_6;
  end

  // s8: combine halves and drop the scaling carried by the divisor
  logic               v8;
  logic [1:0][DVW-1:0] dvd;
  logic [A2W-1:0]     a2_8;
  logic               dgn8;
  logic [N1W-1:0]     num1;
  logic [N2W-1:0]     num2;

  assign num1 = (N1W'(ph1) << P1H) + N1W'(pl1);
  assign num2 = (N2W'(ph2) << H2H) + N2W'(pl2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    dvd[0] <= DVW'(num1[N1W-1:32]);
    dvd[1] <= DVW'(num2[N2W-1:16]);
    a2_8   <= a2_7;
    dgn8   <= (a2_7 == '0);
  end

  logic                          vq;
  logic [1:0][tqm_pkg::QW-1:0]   quo;
  logic                          dgnq;

  tqm_divider u_divider (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (v8),
    .dividend       (dvd),
    .divisor        (a2_8),
    .in_degenerate  (dgn8),
    .out_valid      (vq),
    .quotient       (quo),
    .out_degenerate (dgnq)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
    result.quality_one <= quo[0];
    result.quality_two <= quo[1];
    result.degenerate  <= dgnq;
  end

endmodule
`default_nettype wire

// ===== tb/triangle_quality_measures_test.sv =====
// testbench for triangle_quality_measures: directed and random triangles against a predictor
`timescale 1ns / 1ps
module triangle_quality_measures_test;

  localparam int LIMIT = 200000;
  localparam logic [31:0] QSAT = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  tqm_pkg::vertices_t vertices = '0;
  tqm_pkg::result_t result;

  tqm_pkg::result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  triangle_quality_measures dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertices(vertices), .done(done), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] side_root(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_quotient(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = num / den;
    return (q >> 32) != 0 ? QSAT : q[31:0];
  endfunction

  function automatic tqm_pkg::result_t quality_of(tqm_pkg::vertices_t v);
    longint ax, ay, bx, by, cx, cy, area2;
    logic [63:0] d12, d23, d31, l12, l23, l31, lmax, lsum;
    logic [127:0] hsum;
    tqm_pkg::result_t r;
    ax = v.ax; ay = v.ay; bx = v.bx; by = v.by_coord; cx = v.cx; cy = v.cy;
    d12 = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    d23 = (bx - cx) * (bx - cx) + (by - cy) * (by - cy);
    d31 = (cx - ax) * (cx - ax) + (cy - ay) * (cy - ay);
    l12 = side_root(d12 << 16);
    l23 = side_root(d23 << 16);
    l31 = side_root(d31 << 16);
    lmax = l12;
    if (lmax < l23) lmax = l23;
    if (lmax < l31) lmax = l31;
    lsum = l12 + l23 + l31;
    area2 = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (area2 < 0) area2 = -area2;
    if (area2 == 0) begin
      r.quality_one = QSAT;
      r.quality_two = QSAT;
      r.degenerate = 1'b1;
      return r;
    end
    hsum = 128'(d12) + 128'(d23) + 128'(d31);
    r.quality_one = sat_quotient(128'(lmax) * 128'(lsum) * 128'(tqm_pkg::K_ONE),
                                 128'(area2) << 32);
    r.quality_two = sat_quotient((hsum << 1) * 128'(tqm_pkg::K_TWO), 128'(area2) << 16);
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("error at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  // record the expected result of every accepted item
  always @(posedge clk) begin
    if (!rst && start && !busy) expected_q.push_back(quality_of(vertices));
  end

  always @(posedge clk) begin
    tqm_pkg::result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", result.quality_one, '0);
      end else begin
        want = expected_q.pop_front();
        if (result.quality_one !== want.quality_one)
          report("quality_one", result.quality_one, want.quality_one);
        if (result.quality_two !== want.quality_two)
          report("quality_two", result.quality_two, want.quality_two);
        if (result.degenerate !== want.degenerate)
          report("degenerate", 32'(result.degenerate), 32'(want.degenerate));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("triangle_quality_measures: mismatch");
      $finish;
    end
  end

  task automatic send_item(tqm_pkg::vertices_t v);
    vertices <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic tqm_pkg::vertices_t make_tri(int a, int b, int c, int d, int e, int f);
    tqm_pkg::vertices_t v;
    v.ax = 16'(a); v.ay = 16'(b); v.bx = 16'(c);
    v.by_coord = 16'(d); v.cx = 16'(e); v.cy = 16'(f);
    return v;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_item(make_tri(0, 0, 256, 0, 0, 256));
    send_item(make_tri(0, 0, 256, 0, 128, 222));
    send_item(make_tri(0, 0, 0, 0, 0, 0));
    send_item(make_tri(5, 5, 5, 5, 9, 9));
    send_item(make_tri(0, 0, 100, 100, 200, 200));
    send_item(make_tri(-32768, -32768, 32767, 32767, -32768, 32767));
    send_item(make_tri(-32768, -32768, 32767, -32768, 0, 32767));
    send_item(make_tri(32767, 32767, -32768, -32768, 32767, -32768));
    send_item(make_tri(-32768, 0, 32767, 0, 0, 1));
    send_item(make_tri(-32768, 0, 32767, 0, 32767, 1));
    send_item(make_tri(0, 0, 1, 0, 0, 1));
    send_item(make_tri(-1, -1, 0, 0, 1, 0));
    send_item(make_tri(-32768, -32768, -32767, -32768, -32768, -32767));
    send_item(make_tri(0, 0, 32767, 1, -32768, -1));
    send_item(make_tri(100, -200, -300, 400, 500, 600));
    send_item(make_tri(32767, 0, -32768, 0, 0, 0));
  endtask

  task automatic test_random(int n, int pct);
    tqm_pkg::vertices_t v;
    int kind;
    int s;
    idle_pct = pct;
    repeat (n) begin
      kind = int'($urandom_range(9));
      v = tqm_pkg::vertices_t'({$urandom, $urandom, $urandom});
      if (kind < 3) begin
        // small local triangles
        s = int'($urandom_range(1, 64));
        v.bx = 16'(int'(v.ax) + int'($urandom_range(0, 2 * s)) - s);
        v.by_coord = 16'(int'(v.ay) + int'($urandom_range(0, 2 * s)) - s);
        v.cx = 16'(int'(v.ax) + int'($urandom_range(0, 2 * s)) - s);
        v.cy = 16'(int'(v.ay) + int'($urandom_range(0, 2 * s)) - s);
      end else if (kind < 5) begin
        // collinear or nearly so
        s = int'($urandom_range(0, 40)) - 20;
        v.ax = 16'(int'($urandom_range(0, 4000)) - 2000);
        v.ay = 16'(int'($urandom_range(0, 4000)) - 2000);
        v.bx = 16'(int'(v.ax) + s);
        v.by_coord = 16'(int'(v.ay) + 2 * s);
        v.cx = 16'(int'(v.ax) + 3 * s + int'($urandom_range(0, 2)) - 1);
        v.cy = 16'(int'(v.ay) + 6 * s);
      end else if (kind == 5) begin
        v.cx = v.ax;
        v.cy = v.ay;
      end
      send_item(v);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(150, 0);
    test_random(150, 65);
    test_random(150, 0);
    test_random(150, 33);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_quality_measures: match");
    end else begin
      $display("triangle_quality_measures: mismatch");
    end
    $finish;
  end
endmodule
